>>> design/midi_event_serializer_unit_defines.svh
// assertion macros used by the checker file
`ifndef MIDI_EVENT_SERIALIZER_UNIT_DEFINES_SVH
`define MIDI_EVENT_SERIALIZER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/mes_pkg.sv
package mes_pkg;

	// input opcodes
	localparam logic [2:0] OP_NOTE_ON   = 3'd0;
	localparam logic [2:0] OP_NOTE_OFF  = 3'd1;
	localparam logic [2:0] OP_TRACK_END = 3'd2;
	localparam logic [2:0] OP_TRACK_HDR = 3'd3;
	localparam logic [2:0] OP_FILE_HDR  = 3'd4;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FILE_FORMAT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_QN = 2'd2;

	// status byte bases
	localparam logic [7:0] STATUS_NOTE_ON  = 8'(9 * 16);
	localparam logic [7:0] STATUS_NOTE_OFF = 8'(8 * 16);

	// event byte counts minus one
	localparam logic [4:0] TRACK_END_LAST = 5'd3;
	localparam logic [4:0] TRACK_HDR_LAST = 5'd22;
	localparam logic [4:0] FILE_HDR_LAST  = 5'd13;

	typedef enum logic [1:0] {
		KIND_NOTE,
		KIND_TRACK_END,
		KIND_TRACK_HDR,
		KIND_FILE_HDR
	} kind_t;

	// one classified event waiting for the byte engine
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  grp_m1;
		logic [4:0]  last_idx;
		logic [27:0] delta;
		logic [7:0]  status;
		logic [6:0]  note;
		logic [6:0]  vel;
	} cmd_t;

	typedef struct packed {
		logic [7:0] file_format;
		logic [7:0] track_count;
		logic [7:0] ticks_per_qn;
	} cfg_t;

	// end-of-track meta event
	function automatic logic [7:0] track_end_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd1:    b = 8'hFF;
			2'd2:    b = 8'h2F;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// track chunk header with tempo and 4/4 time signature
	function automatic logic [7:0] track_hdr_byte(input logic [4:0] idx);
		logic [7:0] b;
		case (idx)
			5'd0:    b = 8'h4D;
			5'd1:    b = 8'h54;
			5'd2:    b = 8'h72;
			5'd3:    b = 8'h6B;
			5'd9:    b = 8'hFF;
			5'd10:   b = 8'h51;
			5'd11:   b = 8'h03;
			5'd12:   b = 8'h09;
			5'd13:   b = 8'h27;
			5'd14:   b = 8'hC0;
			5'd16:   b = 8'hFF;
			5'd17:   b = 8'h58;
			5'd18:   b = 8'h04;
			5'd19:   b = 8'h04;
			5'd20:   b = 8'h02;
			5'd21:   b = 8'h18;
			5'd22:   b = 8'h08;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

>>> design/mes_front.sv
module mes_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       opcode,
	input  logic [27:0]      delta_ticks,
	input  logic [3:0]       channel,
	input  logic [6:0]       note_number,
	input  logic [6:0]       velocity,
	output logic             push,
	output mes_pkg::cmd_t    push_cmd,
	input  logic             q_full
);

	logic          valid_s1;
	mes_pkg::cmd_t cmd_s1;
	mes_pkg::cmd_t cmd_d;
	logic          op_ok;
	logic          advance;

	// classify the incoming transaction
	always_comb begin
		cmd_d        = '0;
		op_ok        = 1'b1;
		cmd_d.delta  = delta_ticks;
		cmd_d.note   = note_number;
		cmd_d.vel    = velocity;
		if (delta_ticks[27:21] != 7'd0) begin
			cmd_d.grp_m1 = 2'd3;
		end else if (delta_ticks[20:14] != 7'd0) begin
			cmd_d.grp_m1 = 2'd2;
		end else if (delta_ticks[13:7] != 7'd0) begin
			cmd_d.grp_m1 = 2'd1;
		end else begin
			cmd_d.grp_m1 = 2'd0;
		end
		case (opcode)
			mes_pkg::OP_NOTE_ON: begin
				cmd_d.kind     = mes_pkg::KIND_NOTE;
				cmd_d.status   = mes_pkg::STATUS_NOTE_ON | {4'd0, channel};
				cmd_d.last_idx = 5'd3 + {3'd0, cmd_d.grp_m1};
			end
			mes_pkg::OP_NOTE_OFF: begin
				cmd_d.kind     = mes_pkg::KIND_NOTE;
				cmd_d.status   = mes_pkg::STATUS_NOTE_OFF | {4'd0, channel};
				cmd_d.last_idx = 5'd3 + {3'd0, cmd_d.grp_m1};
			end
			mes_pkg::OP_TRACK_END: begin
				cmd_d.kind     = mes_pkg::KIND_TRACK_END;
				cmd_d.last_idx = mes_pkg::TRACK_END_LAST;
			end
			mes_pkg::OP_TRACK_HDR: begin
				cmd_d.kind     = mes_pkg::KIND_TRACK_HDR;
				cmd_d.last_idx = mes_pkg::TRACK_HDR_LAST;
			end
			mes_pkg::OP_FILE_HDR: begin
				cmd_d.kind     = mes_pkg::KIND_FILE_HDR;
				cmd_d.last_idx = mes_pkg::FILE_HDR_LAST;
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	// stage register, unused opcodes are dropped here
	assign push     = valid_s1 && !q_full;
	assign advance  = !valid_s1 || !q_full;
	assign in_stall = !advance;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid && op_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

>>> design/mes_queue.sv
module mes_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mes_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output mes_pkg::cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mes_pkg::cmd_t slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/mes_back.sv
module mes_back (
	input  logic          clk,
	input  logic          arst_n,
	input  mes_pkg::cfg_t cfg,
	input  logic          q_empty,
	input  mes_pkg::cmd_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          last_byte,
	output logic [4:0]    byte_count
);

	logic [4:0] pos_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic [4:0] count_q;

	logic [2:0] vlq_n;
	logic       in_vlq;
	logic [1:0] grp_sel;
	logic [6:0] grp;
	logic [4:0] data_idx;
	logic [7:0] note_byte;
	logic [7:0] fhdr_byte;
	logic [7:0] byte_d;
	logic       is_last;
	logic       load;

	// note event: delta groups first, then status, note, velocity
	always_comb begin
		vlq_n    = {1'b0, head.grp_m1} + 3'd1;
		in_vlq   = pos_q < {2'b0, vlq_n};
		grp_sel  = head.grp_m1 - pos_q[1:0];
		data_idx = pos_q - {2'b0, vlq_n};
		case (grp_sel)
			2'd0:    grp = head.delta[6:0];
			2'd1:    grp = head.delta[13:7];
			2'd2:    grp = head.delta[20:14];
			default: grp = head.delta[27:21];
		endcase
		if (in_vlq) begin
			note_byte = {grp_sel != 2'd0, grp};
		end else begin
			case (data_idx[1:0])
				2'd0:    note_byte = head.status;
				2'd1:    note_byte = {1'b0, head.note};
				default: note_byte = {1'b0, head.vel};
			endcase
		end
	end

	// file header chunk
	always_comb begin
		case (pos_q)
			5'd0:    fhdr_byte = 8'h4D;
			5'd1:    fhdr_byte = 8'h54;
			5'd2:    fhdr_byte = 8'h68;
			5'd3:    fhdr_byte = 8'h64;
			5'd7:    fhdr_byte = 8'h06;
			5'd9:    fhdr_byte = cfg.file_format;
			5'd11:   fhdr_byte = cfg.track_count;
			5'd13:   fhdr_byte = cfg.ticks_per_qn;
			default: fhdr_byte = 8'h00;
		endcase
	end

	// byte select by event kind
	always_comb begin
		case (head.kind)
			mes_pkg::KIND_NOTE:      byte_d = note_byte;
			mes_pkg::KIND_TRACK_END: byte_d = mes_pkg::track_end_byte(pos_q[1:0]);
			mes_pkg::KIND_TRACK_HDR: byte_d = mes_pkg::track_hdr_byte(pos_q);
			default:                 byte_d = fhdr_byte;
		endcase
	end

	assign is_last = (pos_q == head.last_idx);
	assign load    = !out_valid_q || !out_stall;
	assign pop     = load && !q_empty && is_last;

	// byte position within the current event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				pos_q <= is_last ? 5'd0 : pos_q + 5'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			out_byte_q <= byte_d;
			last_q     <= is_last;
			count_q    <= is_last ? head.last_idx + 5'd1 : 5'd0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign last_byte  = last_q;
	assign byte_count = count_q;

endmodule

>>> design/midi_event_serializer_unit.sv
// standard midi file event serializer
//
// input channel (in_valid / in_stall) takes one event transaction: opcode,
// delta_ticks, channel, note_number, velocity. output channel (out_valid /
// out_stall) gives one byte per transaction with last_byte set on the final
// byte of an event and byte_count holding the event length on that byte.
// cfg_we / cfg_index / cfg_data write the file header fields; write them only
// while the block is idle.
// input events pass the front stage and the event queue to the output
// register. the byte engine sends one byte per cycle while out_stall is low
// and the queue is not empty; an event has 4 to 7 bytes for notes, 4 for track
// end, 23 for track header, 14 for file header. inputs keep being taken while
// earlier events go out, until the event queue (QUEUE_DEPTH entries) plus
// the front stage are full; unused opcodes are dropped without output.
// reset clears the queue and output valid and loads the header defaults.
// when out_stall is high the shown byte holds and the queue fills, then
// in_stall rises.
module midi_event_serializer_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [27:0] delta_ticks,
	input  logic [3:0]  channel,
	input  logic [6:0]  note_number,
	input  logic [6:0]  velocity,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_byte,
	output logic [4:0]  byte_count,
	input  logic        cfg_we,
	input  logic [mes_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]  cfg_data
);

	mes_pkg::cfg_t cfg_q;
	mes_pkg::cmd_t push_cmd;
	mes_pkg::cmd_t head;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;

	// header configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.file_format  <= 8'd0;
			cfg_q.track_count  <= 8'd1;
			cfg_q.ticks_per_qn <= 8'd192;
		end else if (cfg_we) begin
			case (cfg_index)
				mes_pkg::REG_FILE_FORMAT:  cfg_q.file_format  <= cfg_data;
				mes_pkg::REG_TRACK_COUNT:  cfg_q.track_count  <= cfg_data;
				mes_pkg::REG_TICKS_PER_QN: cfg_q.ticks_per_qn <= cfg_data;
				default: ;
			endcase
		end
	end

	mes_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.delta_ticks (delta_ticks),
		.channel     (channel),
		.note_number (note_number),
		.velocity    (velocity),
		.push        (push),
		.push_cmd    (push_cmd),
		.q_full      (q_full)
	);

	mes_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	mes_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last_byte  (last_byte),
		.byte_count (byte_count)
	);

endmodule

>>> design/mes_checker.sv
`include "midi_event_serializer_unit_defines.svh"

module mes_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last_byte,
	input logic [4:0] byte_count
);

	// a stalled transaction holds its byte
	`MES_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last_byte), "stalled output byte changed")

	// byte count shows only on the final byte
	`MES_ASSERT_NOW(a_count_on_last, clk, arst_n, out_valid, last_byte == (byte_count != 5'd0), "byte_count and last_byte disagree")

	// event lengths stay within the known range
	`MES_ASSERT_NOW(a_count_range, clk, arst_n, out_valid && last_byte, byte_count >= 5'd4 && byte_count <= 5'd23, "event length out of range")

	// an event streams without gaps once started
	`MES_ASSERT_NEXT(a_no_gap, clk, arst_n, out_valid && !out_stall && !last_byte, out_valid, "gap inside an event")

endmodule

bind midi_event_serializer_unit mes_checker u_mes_checker (.*);
